FILE: sv/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the page frame replacement block
// Item layouts, register indexes, policy and command codes, and the
// enumerations used by the sequencer.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int unsigned MAX_FRAMES = 16;

  localparam int unsigned FC_W  = 5;
  localparam int unsigned CFG_W = 5;

  // Configuration register indexes.
  localparam logic REG_POLICY      = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  // Policy codes; the unused fourth code behaves as FIFO.
  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  // Command codes.
  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_FAULT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] frame;
    logic       is_write;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_frame;
    logic       writeback;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } pfr_state_t;

  typedef enum logic [1:0] {
    MODE_ANY,
    MODE_FIND,
    MODE_CLOCK
  } pfr_mode_t;

endpackage

FILE: sv/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfr_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/page_frame_replacement.sv
// ----------------------------------------------------------------------------
// page_frame_replacement: victim selection among resident page frames
// FIFO, LRU and enhanced clock policies over a circular frame order list
// kept in a small RAM, walked by one sequencer with a single read port.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  input     start / busy           in_item  (cmd, frame, is_write)
//  result    out_valid (1 cycle)    out_item (chosen_frame, writeback)
//  config    cfg_we                 cfg_idx, cfg_data
//
// A hit outside LRU mode gives its result in the cycle after start.
// FIFO and LRU faults, LRU hits and enhanced clock faults are served by the
// one-entry-per-cycle walk of the order RAM read port over the n active frames.
// Reset is synchronous; the order list needs no clearing pass since each
// entry carries a valid bit. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module page_frame_replacement #(
  parameter int unsigned MAX_FRAMES = pfr_pkg::MAX_FRAMES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  pfr_pkg::in_item_t        in_item,
  output logic                     out_valid,
  output pfr_pkg::out_item_t       out_item,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [pfr_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned FIDX_W  = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned N_RESET = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;

  pfr_pkg::pfr_state_t state_r, state_nxt;
  pfr_pkg::pfr_mode_t  mode_r, mode_nxt;
  logic                pass_r, pass_nxt;
  logic [FIDX_W-1:0]   hand_r, hand_nxt;
  logic [FIDX_W-1:0]   pos_r, pos_nxt;
  logic [FIDX_W-1:0]   rd_pos_r;
  logic                rd_vld_r, rd_vld_nxt;
  logic                vld_q_r;
  logic [FIDX_W-1:0]   ccnt_r, ccnt_nxt;
  logic [FIDX_W-1:0]   w_r, w_nxt;
  logic                sh_vld_r, sh_vld_nxt;
  logic [3:0]          frame_r, frame_nxt;
  logic                wr_r, wr_nxt;
  logic [1:0]          policy_r, policy_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [MAX_FRAMES-1:0] use_r, use_nxt;
  logic [MAX_FRAMES-1:0] dirty_r, dirty_nxt;
  logic [MAX_FRAMES-1:0] ord_vld_r, ord_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  pfr_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                ram_we;
  logic [FIDX_W-1:0]   ram_waddr;
  logic [FIDX_W-1:0]   ram_wdata;
  logic [FIDX_W-1:0]   ram_raddr;
  logic [FIDX_W-1:0]   ram_rdata;

  logic [FIDX_W-1:0]   entry;
  logic [31:0]         entry_ext;
  logic [FIDX_W-1:0]   hit_idx;
  logic [FIDX_W-1:0]   bit_idx;
  logic                cur_use;
  logic                cur_dirty;
  logic                hit_in_range;
  logic [FIDX_W-1:0]   tail;
  logic                match;
  logic [CNT_W-1:0]    n_cfg;

  function automatic logic [FIDX_W-1:0] pos_inc(input logic [FIDX_W-1:0] p,
                                                input logic [CNT_W-1:0]  n);
    logic [FIDX_W-1:0] r;
    if (CNT_W'(p) == n - CNT_W'(1)) begin
      r = '0;
    end else begin
      r = p + FIDX_W'(1);
    end
    return r;
  endfunction

  pfr_ram #(
    .WIDTH (FIDX_W),
    .DEPTH (MAX_FRAMES)
  ) u_order (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry never written since the last frame count change holds its index.
  assign entry     = vld_q_r ? ram_rdata : rd_pos_r;
  assign entry_ext = 32'(entry);
  assign hit_idx   = FIDX_W'({28'd0, in_item.frame});
  assign bit_idx   = (state_r == pfr_pkg::ST_IDLE) ? hit_idx : entry;
  assign cur_use   = use_r[bit_idx];
  assign cur_dirty = dirty_r[bit_idx];
  assign hit_in_range = ({28'd0, in_item.frame} < 32'(n_r));
  assign tail = (hand_r == '0) ? FIDX_W'(n_r - CNT_W'(1)) : hand_r - FIDX_W'(1);

  always_comb begin
    if (cfg_data == '0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_FRAMES)) begin
      n_cfg = CNT_W'(MAX_FRAMES);
    end else begin
      n_cfg = CNT_W'(cfg_data);
    end
  end

  always_comb begin
    unique case (mode_r)
      pfr_pkg::MODE_ANY:   match = 1'b1;
      pfr_pkg::MODE_FIND:  match = (entry_ext[3:0] == frame_r) && (entry_ext[31:4] == '0);
      pfr_pkg::MODE_CLOCK: match = !cur_use && (cur_dirty == pass_r);
      default:             match = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pass_nxt      = pass_r;
    hand_nxt      = hand_r;
    pos_nxt       = pos_r;
    rd_vld_nxt    = rd_vld_r;
    ccnt_nxt      = ccnt_r;
    w_nxt         = w_r;
    sh_vld_nxt    = sh_vld_r;
    frame_nxt     = frame_r;
    wr_nxt        = wr_r;
    policy_nxt    = policy_r;
    n_nxt         = n_r;
    use_nxt       = use_r;
    dirty_nxt     = dirty_r;
    ord_vld_nxt   = ord_vld_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = w_r;
    ram_wdata     = entry;
    ram_raddr     = pos_r;

    unique case (state_r)
      pfr_pkg::ST_IDLE: begin
        if (cfg_we) begin
          unique case (cfg_idx)
            pfr_pkg::REG_POLICY: begin
              policy_nxt = cfg_data[1:0];
            end
            pfr_pkg::REG_FRAME_COUNT: begin
              n_nxt       = n_cfg;
              hand_nxt    = '0;
              ord_vld_nxt = '0;
            end
            default: begin
            end
          endcase
        end
        if (start) begin
          frame_nxt  = in_item.frame;
          wr_nxt     = in_item.is_write;
          pos_nxt    = hand_r;
          ccnt_nxt   = '0;
          pass_nxt   = 1'b0;
          rd_vld_nxt = 1'b0;
          if (in_item.cmd == pfr_pkg::CMD_HIT) begin
            if (hit_in_range) begin
              use_nxt[hit_idx]   = 1'b1;
              dirty_nxt[hit_idx] = cur_dirty | in_item.is_write;
            end
            if (hit_in_range && (policy_r == pfr_pkg::POL_LRU)) begin
              mode_nxt  = pfr_pkg::MODE_FIND;
              state_nxt = pfr_pkg::ST_SCAN;
            end else begin
              out_valid_nxt             = 1'b1;
              out_item_nxt.chosen_frame = in_item.frame;
              out_item_nxt.writeback    = 1'b0;
            end
          end else begin
            mode_nxt  = (policy_r == pfr_pkg::POL_CLOCK) ? pfr_pkg::MODE_CLOCK
                                                         : pfr_pkg::MODE_ANY;
            state_nxt = pfr_pkg::ST_SCAN;
          end
        end
      end

      // Reads stream around the list from the hand, one per cycle; the
      // entry read in the previous cycle is judged while the next is fetched.
      pfr_pkg::ST_SCAN: begin
        ram_raddr  = pos_r;
        pos_nxt    = pos_inc(pos_r, n_r);
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          if (match) begin
            rd_vld_nxt = 1'b0;
            if (mode_r == pfr_pkg::MODE_FIND) begin
              w_nxt      = rd_pos_r;
              sh_vld_nxt = 1'b0;
              state_nxt  = pfr_pkg::ST_SHIFT;
            end else begin
              hand_nxt                  = pos_inc(rd_pos_r, n_r);
              use_nxt[entry]            = 1'b1;
              dirty_nxt[entry]          = wr_r;
              out_valid_nxt             = 1'b1;
              out_item_nxt.chosen_frame = entry_ext[3:0];
              out_item_nxt.writeback    = cur_dirty;
              state_nxt                 = pfr_pkg::ST_IDLE;
            end
          end else begin
            if (pass_r) begin
              use_nxt[entry] = 1'b0;
            end
            if (CNT_W'(ccnt_r) == n_r - CNT_W'(1)) begin
              ccnt_nxt = '0;
              pass_nxt = !pass_r;
            end else begin
              ccnt_nxt = ccnt_r + FIDX_W'(1);
            end
          end
        end
      end

      // Each entry after the hit frame moves one place toward the head,
      // then the hit frame lands at the tail.
      pfr_pkg::ST_SHIFT: begin
        ram_raddr = pos_inc(w_r, n_r);
        if (w_r == tail) begin
          ram_we                    = 1'b1;
          ram_waddr                 = tail;
          ram_wdata                 = FIDX_W'({28'd0, frame_r});
          ord_vld_nxt[tail]         = 1'b1;
          out_valid_nxt             = 1'b1;
          out_item_nxt.chosen_frame = frame_r;
          out_item_nxt.writeback    = 1'b0;
          state_nxt                 = pfr_pkg::ST_IDLE;
        end else if (!sh_vld_r) begin
          sh_vld_nxt = 1'b1;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = w_r;
          ram_wdata        = entry;
          ord_vld_nxt[w_r] = 1'b1;
          w_nxt            = pos_inc(w_r, n_r);
          ram_raddr        = pos_inc(w_nxt, n_r);
          sh_vld_nxt       = (w_nxt != tail);
        end
      end

      default: begin
        state_nxt = pfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfr_pkg::ST_IDLE;
      mode_r      <= pfr_pkg::MODE_ANY;
      pass_r      <= 1'b0;
      hand_r      <= '0;
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      ccnt_r      <= '0;
      sh_vld_r    <= 1'b0;
      policy_r    <= pfr_pkg::POL_FIFO;
      n_r         <= CNT_W'(N_RESET);
      use_r       <= '0;
      dirty_r     <= '0;
      ord_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pass_r      <= pass_nxt;
      hand_r      <= hand_nxt;
      pos_r       <= pos_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ccnt_r      <= ccnt_nxt;
      sh_vld_r    <= sh_vld_nxt;
      policy_r    <= policy_nxt;
      n_r         <= n_nxt;
      use_r       <= use_nxt;
      dirty_r     <= dirty_nxt;
      ord_vld_r   <= ord_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r   <= ram_raddr;
    vld_q_r    <= ord_vld_r[ram_raddr];
    w_r        <= w_nxt;
    frame_r    <= frame_nxt;
    wr_r       <= wr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != pfr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/pfr_chk.sv
// ----------------------------------------------------------------------------
// pfr_chk: port-level checks for page_frame_replacement
// Watches the command and result handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module pfr_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input pfr_pkg::in_item_t  in_item,
  input logic               out_valid,
  input pfr_pkg::out_item_t out_item
);

  // A result leaves the block idle in the same cycle.
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Work only ends by delivering a result.
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

  // A fault always needs the sequencer.
  a_fault_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == pfr_pkg::CMD_FAULT) |=> (busy && !out_valid))
    else $error("fault did not start a scan");

  // A hit either answers at once with its own frame or starts an LRU move.
  a_hit_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == pfr_pkg::CMD_HIT) |=>
      ((out_valid && out_item.chosen_frame == $past(in_item.frame) && !out_item.writeback)
       || (busy && !out_valid)))
    else $error("hit result wrong");

endmodule

bind page_frame_replacement pfr_chk u_pfr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
